@@ rtl/cetm_pkg.sv @@
// shared constants and types for the cron entry time matcher
`default_nettype none

package cetm_pkg;

  // table codes
  localparam logic [7:0] CODE_EXACT = 8'd100;
  localparam logic [7:0] CODE_ANY   = 8'd101;
  localparam logic [7:0] CODE_LIST  = 8'd102;
  localparam logic [7:0] CODE_RANGE = 8'd103;
  localparam logic [7:0] CODE_END   = 8'd104;
  localparam logic [7:0] SUNDAY_VAL = 8'd7;
  localparam logic [7:0] CMD_TERM   = 8'd0;

  // field order within an entry
  localparam logic [2:0] FLD_MINUTE  = 3'd0;
  localparam logic [2:0] FLD_HOUR    = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_WEEKDAY = 3'd4;

  // register indexes (paddr[4:2])
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_MINUTE  = 3'd0;
  localparam logic [2:0] REG_HOUR    = 3'd1;
  localparam logic [2:0] REG_DAY     = 3'd2;
  localparam logic [2:0] REG_MONTH   = 3'd3;
  localparam logic [2:0] REG_WEEKDAY = 3'd4;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [2:0] weekday;
  } now_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] cmd_byte;
    logic       eoc;
    logic       done;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/cetm_cfg.sv @@
// register bank holding the current time, written over the config port
`default_nettype none

module cetm_cfg
  import cetm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready,
  output now_t                   now
);

  now_t       now_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign now        = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r.minute  <= 6'd0;
      now_r.hour    <= 5'd0;
      now_r.day     <= 5'd1;
      now_r.month   <= 4'd0;
      now_r.weekday <= 3'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MINUTE:  now_r.minute  <= cfg_pwdata[5:0];
        REG_HOUR:    now_r.hour    <= cfg_pwdata[4:0];
        REG_DAY:     now_r.day     <= cfg_pwdata[4:0];
        REG_MONTH:   now_r.month   <= cfg_pwdata[3:0];
        REG_WEEKDAY: now_r.weekday <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MINUTE:  cfg_prdata = {26'd0, now_r.minute};
      REG_HOUR:    cfg_prdata = {27'd0, now_r.hour};
      REG_DAY:     cfg_prdata = {27'd0, now_r.day};
      REG_MONTH:   cfg_prdata = {28'd0, now_r.month};
      REG_WEEKDAY: cfg_prdata = {29'd0, now_r.weekday};
      default:     cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cetm_match.sv @@
// per-byte parser state and field matching for the schedule table
`default_nettype none

module cetm_match
  import cetm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] tbyte,
  input  now_t            now,
  output res_t            res
);

  typedef enum logic [2:0] {
    PH_CODE, PH_EXACT, PH_LIST, PH_RLOW, PH_RHIGH, PH_CMD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] field_idx_r, field_idx_nxt;
  logic       mismatch_r, mismatch_nxt;
  logic       list_hit_r, list_hit_nxt;
  logic [7:0] range_low_r, range_low_nxt;
  logic [7:0] tval;
  logic       last_field;
  phase_t     done_phase;
  logic [2:0] done_idx;

  // time value for the field under test
  always_comb begin
    case (field_idx_r)
      FLD_MINUTE: tval = {2'd0, now.minute};
      FLD_HOUR:   tval = {3'd0, now.hour};
      FLD_DAY:    tval = {3'd0, now.day};
      FLD_MONTH:  tval = {4'd0, now.month} + 8'd1;
      default:    tval = (now.weekday == 3'd0) ? SUNDAY_VAL : {5'd0, now.weekday};
    endcase
  end

  // where a finished field leads
  assign last_field = (field_idx_r == FLD_WEEKDAY);
  assign done_phase = last_field ? PH_CMD : PH_CODE;
  assign done_idx   = last_field ? FLD_MINUTE : field_idx_r + 3'd1;

  always_comb begin
    phase_nxt     = phase_r;
    field_idx_nxt = field_idx_r;
    mismatch_nxt  = mismatch_r;
    list_hit_nxt  = list_hit_r;
    range_low_nxt = range_low_r;
    res           = '0;
    case (phase_r)
      PH_CODE: begin
        if (field_idx_r == FLD_MINUTE && tbyte == CODE_END) begin
          mismatch_nxt = 1'b0;
          res.emit     = 1'b1;
          res.done     = 1'b1;
        end else if (tbyte == CODE_EXACT) begin
          phase_nxt = PH_EXACT;
        end else if (tbyte == CODE_ANY) begin
          phase_nxt     = done_phase;
          field_idx_nxt = done_idx;
        end else if (tbyte == CODE_LIST) begin
          list_hit_nxt = 1'b0;
          phase_nxt    = PH_LIST;
        end else if (tbyte == CODE_RANGE) begin
          phase_nxt = PH_RLOW;
        end else begin
          // bare exact value
          if (tbyte != tval) mismatch_nxt = 1'b1;
          phase_nxt     = done_phase;
          field_idx_nxt = done_idx;
        end
      end
      PH_EXACT: begin
        if (tbyte != tval) mismatch_nxt = 1'b1;
        phase_nxt     = done_phase;
        field_idx_nxt = done_idx;
      end
      PH_LIST: begin
        if (tbyte == CODE_LIST) begin
          if (!list_hit_r) mismatch_nxt = 1'b1;
          list_hit_nxt  = 1'b0;
          phase_nxt     = done_phase;
          field_idx_nxt = done_idx;
        end else if (tbyte == tval) begin
          list_hit_nxt = 1'b1;
        end
      end
      PH_RLOW: begin
        range_low_nxt = tbyte;
        phase_nxt     = PH_RHIGH;
      end
      PH_RHIGH: begin
        if (range_low_r > tval || tbyte < tval) mismatch_nxt = 1'b1;
        phase_nxt     = done_phase;
        field_idx_nxt = done_idx;
      end
      PH_CMD: begin
        res.emit     = !mismatch_r;
        res.cmd_byte = tbyte;
        res.eoc      = (tbyte == CMD_TERM);
        if (tbyte == CMD_TERM) begin
          phase_nxt     = PH_CODE;
          field_idx_nxt = FLD_MINUTE;
          mismatch_nxt  = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CODE;
      field_idx_r <= FLD_MINUTE;
      mismatch_r  <= 1'b0;
      list_hit_r  <= 1'b0;
      range_low_r <= 8'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      field_idx_r <= field_idx_nxt;
      mismatch_r  <= mismatch_nxt;
      list_hit_r  <= list_hit_nxt;
      range_low_r <= range_low_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cron_entry_time_matcher.sv @@
// an accepted table byte's item, if it yields one, is registered and shown on the out side in the next cycle
// throughput: one table byte per cycle while the out side is not stalled, set by the single parser state update
// a result register decouples the sides; input is taken while it is empty or holds an item being drained
// reset (synchronous, rst_n low): parser at the start of an entry, output empty,
// time registers at minute 0, hour 0, day 1, january, sunday
`default_nettype none

module cron_entry_time_matcher
  import cetm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata: [7:0] table_byte
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  // out_tdata: [7:0] command_byte; out_tlast: end_of_command
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  // out_tuser: [0] scan_done
  output logic                   out_tuser,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  now_t       now;
  res_t       res;
  logic       in_acc;
  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       out_tuser_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  cetm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .now         (now)
  );

  cetm_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .tbyte  (in_tdata),
    .now    (now),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_acc) begin
      out_tvalid_r <= res.emit;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.emit) begin
      out_tdata_r <= res.cmd_byte;
      out_tlast_r <= res.eoc;
      out_tuser_r <= res.done;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == CMD_TERM && !out_tlast)
    else $error("scan_done item carries command data");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == CMD_TERM)
    else $error("end of command on a nonzero byte");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire

@@ tb/sv/cetm_match_checker.sv @@
// checker for the cron entry time matcher: tracks the table parser and compares output items
module cetm_match_checker
  import cetm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [7:0]        out_tdata,
  input  wire logic              out_tlast,
  input  wire logic              out_tuser,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic              cfg_pready,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output int                     fail_count,
  output int                     pending,
  output logic                   at_entry_start
);

  typedef enum logic [2:0] {
    P_CODE, P_EXACT, P_LIST, P_RLOW, P_RHIGH, P_CMD
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic       eoc;
    logic       done;
  } sched_item_t;

  now_t         now;
  parse_phase_t phase;
  logic [2:0]   fld;
  logic         miss;
  logic         hit;
  logic [7:0]   low_bound;
  sched_item_t  sched_items_q[$];
  int           errs = 0;

  // value the current field is compared against
  function automatic logic [7:0] field_target(input logic [2:0] f, input now_t t);
    case (f)
      FLD_MINUTE: return {2'b00, t.minute};
      FLD_HOUR:   return {3'b000, t.hour};
      FLD_DAY:    return {3'b000, t.day};
      FLD_MONTH:  return {4'b0000, t.month} + 8'd1;
      default:    return (t.weekday == 3'd0) ? SUNDAY_VAL : {5'b00000, t.weekday};
    endcase
  endfunction

  task automatic next_field();
    if (fld == FLD_WEEKDAY) begin
      fld = FLD_MINUTE;
      phase = P_CMD;
    end else begin
      fld = fld + 3'd1;
      phase = P_CODE;
    end
  endtask

  task automatic queue_item(input logic [7:0] cmd, input logic eoc, input logic done);
    sched_item_t it;
    it.cmd = cmd;
    it.eoc = eoc;
    it.done = done;
    sched_items_q.push_back(it);
  endtask

  task automatic parse_table_byte(input logic [7:0] b);
    logic [7:0] v;
    logic       emit;
    v = field_target(fld, now);
    case (phase)
      P_CODE: begin
        if (fld == FLD_MINUTE && b == CODE_END) begin
          miss = 1'b0;
          queue_item(CMD_TERM, 1'b0, 1'b1);
        end else if (b == CODE_EXACT) begin
          phase = P_EXACT;
        end else if (b == CODE_ANY) begin
          next_field();
        end else if (b == CODE_LIST) begin
          hit = 1'b0;
          phase = P_LIST;
        end else if (b == CODE_RANGE) begin
          phase = P_RLOW;
        end else begin
          // bare value, the end code inside an entry lands here too
          if (b != v) miss = 1'b1;
          next_field();
        end
      end
      P_EXACT: begin
        if (b != v) miss = 1'b1;
        next_field();
      end
      P_LIST: begin
        if (b == CODE_LIST) begin
          if (!hit) miss = 1'b1;
          hit = 1'b0;
          next_field();
        end else if (b == v) begin
          hit = 1'b1;
        end
      end
      P_RLOW: begin
        low_bound = b;
        phase = P_RHIGH;
      end
      P_RHIGH: begin
        if (low_bound > v || b < v) miss = 1'b1;
        next_field();
      end
      default: begin
        emit = !miss;
        if (b == CMD_TERM) begin
          phase = P_CODE;
          fld = FLD_MINUTE;
          miss = 1'b0;
        end
        if (emit) queue_item(b, b == CMD_TERM, 1'b0);
      end
    endcase
  endtask

  task automatic write_time_reg(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      REG_MINUTE:  now.minute = d[5:0];
      REG_HOUR:    now.hour = d[4:0];
      REG_DAY:     now.day = d[4:0];
      REG_MONTH:   now.month = d[3:0];
      REG_WEEKDAY: now.weekday = d[2:0];
      default: ;
    endcase
  endtask

  task automatic compare_item();
    sched_item_t exp_it;
    if (sched_items_q.size() == 0) begin
      $error("unexpected item: command_byte %0d end_of_command %0b scan_done %0b",
             out_tdata, out_tlast, out_tuser);
      errs++;
    end else begin
      exp_it = sched_items_q.pop_front();
      if (out_tdata !== exp_it.cmd) begin
        $error("command_byte: expected %0d, got %0d", exp_it.cmd, out_tdata);
        errs++;
      end
      if (out_tlast !== exp_it.eoc) begin
        $error("end_of_command: expected %0b, got %0b", exp_it.eoc, out_tlast);
        errs++;
      end
      if (out_tuser !== exp_it.done) begin
        $error("scan_done: expected %0b, got %0b", exp_it.done, out_tuser);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      now.minute = 6'd0;
      now.hour = 5'd0;
      now.day = 5'd1;
      now.month = 4'd0;
      now.weekday = 3'd0;
      phase = P_CODE;
      fld = FLD_MINUTE;
      miss = 1'b0;
      hit = 1'b0;
      low_bound = 8'd0;
      sched_items_q.delete();
    end else begin
      // an item cannot leave on the edge that takes its table byte, so pop first
      if (out_tvalid && out_tready) compare_item();
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_time_reg(cfg_paddr[4:2], cfg_pwdata);
      if (in_tvalid && in_tready) parse_table_byte(in_tdata);
    end
    pending <= sched_items_q.size();
    fail_count <= errs;
    at_entry_start <= (phase == P_CODE) && (fld == FLD_MINUTE);
  end

endmodule

@@ tb/sv/cron_entry_time_matcher_test.sv @@
// testbench top for the cron entry time matcher: schedule table stimulus and verdict
module cron_entry_time_matcher_test;
  import cetm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 150;
  localparam int RAND_ROUNDS  = 8;
  localparam int ROUND_ITEMS  = 170;

  typedef enum int {SPEC_EXACT, SPEC_ANY, SPEC_LIST, SPEC_RANGE, SPEC_BARE} spec_kind_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int         fail_count;
  int         pending;
  logic       at_entry_start;
  int         cycle_count = 0;
  int         sent_items = 0;
  logic       calm = 1'b0;
  logic       long_hold_req = 1'b0;
  logic [7:0] aim [5];

  always #2 clk = ~clk;

  cron_entry_time_matcher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  cetm_match_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending), .at_entry_start(at_entry_start)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("cron_entry_time_matcher_test failed");
      $finish;
    end
  end

  // receiver: random stall per item, one long hold-off on request
  initial begin : receiver
    int gap;
    out_tready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // junk above the register width must be ignored
  function automatic logic [31:0] junk_above(input int w);
    return ($urandom() >> w) << w;
  endfunction

  task automatic set_time(input logic [5:0] m, input logic [4:0] h, input logic [4:0] d,
                          input logic [3:0] mo, input logic [2:0] wd);
    cfg_write(REG_MINUTE, junk_above(6) | 32'(m));
    cfg_write(REG_HOUR, junk_above(5) | 32'(h));
    cfg_write(REG_DAY, junk_above(5) | 32'(d));
    cfg_write(REG_MONTH, junk_above(4) | 32'(mo));
    cfg_write(REG_WEEKDAY, junk_above(3) | 32'(wd));
    aim[FLD_MINUTE] = {2'b00, m};
    aim[FLD_HOUR] = {3'b000, h};
    aim[FLD_DAY] = {3'b000, d};
    aim[FLD_MONTH] = {4'b0000, mo} + 8'd1;
    aim[FLD_WEEKDAY] = (wd == 3'd0) ? SUNDAY_VAL : {5'b00000, wd};
  endtask

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    sent_items++;
  endtask

  // stop offering, let every expected item drain, then a few quiet cycles
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] avoid_a, input logic [7:0] avoid_b);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid_a || b == avoid_b);
    return b;
  endfunction

  task automatic send_field(input int f, input bit want_hit);
    logic [7:0] v;
    logic [7:0] b;
    spec_kind_t kind;
    int         n;
    int         pos;
    v = aim[f];
    kind = spec_kind_t'($urandom_range(0, 4));
    if (!want_hit && kind == SPEC_ANY) kind = SPEC_EXACT;
    case (kind)
      SPEC_EXACT: begin
        push_byte(CODE_EXACT);
        push_byte(want_hit ? v : pick_byte(v, v));
      end
      SPEC_ANY: push_byte(CODE_ANY);
      SPEC_LIST: begin
        n = $urandom_range(0, 4);
        if (want_hit && n == 0) n = 1;
        pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
        push_byte(CODE_LIST);
        for (int i = 0; i < n; i++) begin
          if (want_hit && i == pos) push_byte(v);
          else if (want_hit) push_byte(pick_byte(CODE_LIST, CODE_LIST));
          else push_byte(pick_byte(CODE_LIST, v));
        end
        push_byte(CODE_LIST);
      end
      SPEC_RANGE: begin
        push_byte(CODE_RANGE);
        if (want_hit) begin
          push_byte(8'($urandom_range(0, v)));
          push_byte(8'($urandom_range(v, 255)));
        end else if (v == 8'd0 || $urandom_range(0, 1) == 0) begin
          push_byte(8'($urandom_range(v + 1, 255)));
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(8'($urandom_range(0, 255)));
          push_byte(8'($urandom_range(0, v - 1)));
        end
      end
      default: begin
        if (want_hit) begin
          push_byte(v);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == v || (b >= CODE_EXACT && b <= CODE_END));
          push_byte(b);
        end
      end
    endcase
  endtask

  task automatic send_entry(input bit want_match, input int cmd_len);
    int miss_f;
    miss_f = $urandom_range(0, 4);
    for (int f = 0; f < 5; f++)
      send_field(f, want_match ? 1'b1 : (f == miss_f ? 1'b0 : 1'($urandom_range(0, 1))));
    repeat (cmd_len) push_byte(8'($urandom_range(1, 255)));
    push_byte(CMD_TERM);
  endtask

  task automatic send_scan();
    int n;
    int len;
    n = $urandom_range(1, 3);
    repeat (n) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
      send_entry($urandom_range(0, 9) < 6, len);
    end
    push_byte(CODE_END);
  endtask

  // random bytes, then zeros with an occasional list code until back at an entry start
  task automatic noise_burst();
    int n;
    int k;
    n = $urandom_range(4, 16);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
    k = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!at_entry_start) begin
      push_byte((k % 4 == 3) ? CODE_LIST : CMD_TERM);
      k++;
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int  start;
    bit  pressure_done;
    pressure_done = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'd0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_time(6'd59, 5'd23, 5'd31, 4'd11, 3'd0);
    // end code at the start of an entry
    push_byte(CODE_END);
    // matching entry: list hit then more elements, sunday as 7, full-range ends
    push_byte(CODE_EXACT); push_byte(8'd59);
    push_byte(CODE_ANY);
    push_byte(CODE_LIST); push_byte(8'd31); push_byte(8'd5); push_byte(CODE_LIST);
    push_byte(CODE_RANGE); push_byte(8'd12); push_byte(8'd12);
    push_byte(SUNDAY_VAL);
    push_byte(8'd255); push_byte(CMD_TERM);
    // empty list and end code inside an entry: whole entry stays silent
    push_byte(CODE_LIST); push_byte(CODE_LIST);
    push_byte(CODE_END);
    push_byte(CODE_RANGE); push_byte(8'd0); push_byte(8'd255);
    push_byte(CODE_EXACT); push_byte(8'd0);
    push_byte(CODE_ANY);
    push_byte(8'd1); push_byte(CMD_TERM);

    for (int r = 0; r < RAND_ROUNDS; r++) begin
      settle();
      case (r)
        0: set_time(6'd59, 5'd23, 5'd31, 4'd11, 3'd6);
        1: set_time(6'd0, 5'd0, 5'd1, 4'd0, 3'd0);
        2: set_time(6'd63, 5'd31, 5'd0, 4'd15, 3'd7);
        default: begin
          if ($urandom_range(0, 3) == 0)
            set_time(6'($urandom()), 5'($urandom()), 5'($urandom()), 4'($urandom()),
                     3'($urandom()));
          else
            set_time(6'($urandom_range(0, 59)), 5'($urandom_range(0, 23)),
                     5'($urandom_range(1, 31)), 4'($urandom_range(0, 11)),
                     3'($urandom_range(0, 6)));
        end
      endcase
      calm = (r % 3 == 2);
      start = sent_items;
      while (sent_items - start < ROUND_ITEMS) begin
        if (r == 1 && !pressure_done) begin
          // long command while the receiver holds off: output fills, input stalls
          long_hold_req = 1'b1;
          send_entry(1'b1, 30);
          push_byte(CODE_END);
          pressure_done = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          noise_burst();
        end else begin
          send_scan();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("cron_entry_time_matcher_test passed");
    end else begin
      $display("cron_entry_time_matcher_test failed");
    end
    $finish;
  end

endmodule
